// ===== hdl/bts_pkg.sv =====
// Shared types and constants for the block transfer sender.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package bts_pkg;

   // Data block size in bytes (module parameter default, range 1 to 127)
   localparam int BLOCK_BYTES = 64;

   localparam int IMAGE_W   = 22;
   localparam int RETRY_W   = 8;
   localparam int BLOCK_W   = 16;
   localparam int PAYLOAD_W = 7;
   localparam int CODE_W    = 3;
   // Holds 65535 * 127, the largest byte offset over the BLOCK_BYTES range
   localparam int OFFSET_W  = 23;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [RETRY_W-1:0] RETRY_RESET = 8'd5;
   localparam logic [BLOCK_W-1:0] META_ACK    = 16'hFFFF;
   localparam logic [BLOCK_W-1:0] BLOCK_MAX   = 16'hFFFF;

   // Command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_ACK  = 1'b1;

   // Register index, taken from paddr[2]
   localparam logic REG_IMAGE_BYTES = 1'b0;
   localparam logic REG_RETRY_LIMIT = 1'b1;

   typedef enum logic [CODE_W-1:0] {
      PH_INIT  = 3'd0,
      PH_META  = 3'd1,
      PH_DATA  = 3'd2,
      PH_DONE  = 3'd3,
      PH_ERROR = 3'd4
   } phase_type;

   typedef enum logic [CODE_W-1:0] {
      ACT_NONE   = 3'd0,
      ACT_META   = 3'd1,
      ACT_DATA   = 3'd2,
      ACT_FINISH = 3'd3,
      ACT_ABORT  = 3'd4
   } action_type;

   typedef struct packed {
      logic [IMAGE_W-1:0] image_bytes;
      logic [RETRY_W-1:0] retry_limit;
      logic [BLOCK_W-1:0] block_total;
   } cfg_type;

   typedef struct packed {
      logic               cmd;
      logic               link_ready;
      logic [BLOCK_W-1:0] ack_block;
      logic               negative;
   } item_type;

   typedef struct packed {
      action_type           action;
      logic [BLOCK_W-1:0]   block_number;
      logic [IMAGE_W-1:0]   byte_offset;
      logic [PAYLOAD_W-1:0] payload_bytes;
      logic [BLOCK_W-1:0]   block_total;
      phase_type            phase_now;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/bts_cfg.sv =====
// Configuration registers on an APB-style port, plus the block count
// derived from the image size at write time. Depends on bts_pkg.
`default_nettype none

module bts_cfg #(
   parameter int BlockBytes = bts_pkg::BLOCK_BYTES
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [bts_pkg::ADDR_W-1:0] paddr,
   input  wire logic [bts_pkg::DATA_W-1:0] pwdata,
   output logic      [bts_pkg::DATA_W-1:0] prdata,
   output logic                            pready,
   output bts_pkg::cfg_type                cfg
);
   import bts_pkg::*;

   // Exact floor(n / BlockBytes) for n below 2^(IMAGE_W+1) by reciprocal multiply
   localparam int NUM_W   = IMAGE_W + 1;
   localparam int SHIFT   = NUM_W + $clog2(BlockBytes);
   localparam int RECIP_W = NUM_W + 2;
   localparam int PROD_W  = NUM_W + RECIP_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(BlockBytes) - 64'd1) / 64'(BlockBytes);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   logic [IMAGE_W-1:0] image_bytes_ff, image_bytes_in;
   logic [RETRY_W-1:0] retry_limit_ff, retry_limit_in;
   logic [BLOCK_W-1:0] block_total_ff, block_total_in;

   logic               write_en;
   logic [NUM_W-1:0]   numer;
   logic [PROD_W-1:0]  product;
   logic [PROD_W-1:0]  quotient;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;

   // Round up the image size to whole blocks and saturate to 16 bits
   always_comb begin
      numer    = NUM_W'(pwdata[IMAGE_W-1:0]) + NUM_W'(BlockBytes - 1);
      product  = PROD_W'(numer) * PROD_W'(RECIP);
      quotient = product >> SHIFT;
   end

   always_comb begin
      image_bytes_in = image_bytes_ff;
      retry_limit_in = retry_limit_ff;
      block_total_in = block_total_ff;
      if (write_en) begin
         case (paddr[2])
            REG_IMAGE_BYTES: begin
               image_bytes_in = pwdata[IMAGE_W-1:0];
               block_total_in = (|quotient[PROD_W-1:BLOCK_W]) ? BLOCK_MAX
                                                               : quotient[BLOCK_W-1:0];
            end
            REG_RETRY_LIMIT: begin
               retry_limit_in = pwdata[RETRY_W-1:0];
            end
            default: begin
               image_bytes_in = image_bytes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_bytes_ff <= '0;
         retry_limit_ff <= RETRY_RESET;
         block_total_ff <= '0;
      end else begin
         image_bytes_ff <= image_bytes_in;
         retry_limit_ff <= retry_limit_in;
         block_total_ff <= block_total_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_IMAGE_BYTES: prdata = DATA_W'(image_bytes_ff);
         REG_RETRY_LIMIT: prdata = DATA_W'(retry_limit_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.image_bytes = image_bytes_ff;
   assign cfg.retry_limit = retry_limit_ff;
   assign cfg.block_total = block_total_ff;

endmodule

`default_nettype wire

// ===== hdl/bts_core.sv =====
// Sender state machine: phase, block counter, retry counter and ack flag,
// with the per-event result logic. Depends on bts_pkg.
`default_nettype none

module bts_core #(
   parameter int BlockBytes = bts_pkg::BLOCK_BYTES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire bts_pkg::item_type    item,
   input  wire bts_pkg::cfg_type     cfg,
   output bts_pkg::result_type       result
);
   import bts_pkg::*;

   localparam logic [7:0] BLOCK_LEN = 8'(BlockBytes);

   phase_type          phase_ff, phase_in;
   logic [BLOCK_W-1:0] next_block_ff, next_block_in;
   logic [RETRY_W-1:0] retries_ff, retries_in;
   logic               acked_ff, acked_in;

   logic                is_tick;
   logic                data_tick;
   logic                finish;
   logic                abort;
   logic                send_data;
   logic                block_ack;
   logic [RETRY_W-1:0]  retries_inc;
   logic [OFFSET_W-1:0] offset;
   logic [OFFSET_W-1:0] remain;
   logic [7:0]          payload;

   always_comb begin
      is_tick     = (item.cmd == CMD_TICK);
      data_tick   = is_tick && (phase_ff == PH_DATA);
      retries_inc = retries_ff + 1'b1;
      finish      = data_tick && (next_block_ff >= cfg.block_total);
      abort       = data_tick && !finish && !acked_ff && (retries_inc >= cfg.retry_limit);
      send_data   = data_tick && !finish && !abort && item.link_ready;
      block_ack   = (item.cmd == CMD_ACK) && (item.ack_block != META_ACK) &&
                    (phase_ff == PH_DATA) && !item.negative &&
                    (item.ack_block == next_block_ff);
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_INIT: begin
            if (is_tick && item.link_ready) phase_in = PH_META;
         end
         PH_META: begin
            if (!is_tick && (item.ack_block == META_ACK)) phase_in = PH_DATA;
         end
         PH_DATA: begin
            if (finish)     phase_in = PH_DONE;
            else if (abort) phase_in = PH_ERROR;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Block, retry and ack bookkeeping
   always_comb begin
      next_block_in = next_block_ff;
      retries_in    = retries_ff;
      acked_in      = acked_ff;
      if (data_tick && !finish) begin
         if (acked_ff) begin
            retries_in = '0;
            acked_in   = 1'b0;
         end else begin
            retries_in = retries_inc;
         end
      end
      if (block_ack) begin
         acked_in      = 1'b1;
         next_block_in = next_block_ff + 1'b1;
      end
   end

   // Result fields
   always_comb begin
      offset  = OFFSET_W'(next_block_ff) * OFFSET_W'(BlockBytes);
      remain  = (offset < OFFSET_W'(cfg.image_bytes)) ? OFFSET_W'(cfg.image_bytes) - offset
                                                       : '0;
      payload = (remain >= OFFSET_W'(BLOCK_LEN)) ? BLOCK_LEN : remain[7:0];

      result.action        = ACT_NONE;
      result.block_number  = next_block_ff;
      result.byte_offset   = '0;
      result.payload_bytes = '0;
      result.block_total   = cfg.block_total;
      result.phase_now     = phase_in;
      if (finish) begin
         result.action = ACT_FINISH;
      end else if (abort) begin
         result.action = ACT_ABORT;
      end else if (send_data) begin
         result.action        = ACT_DATA;
         result.byte_offset   = offset[IMAGE_W-1:0];
         result.payload_bytes = payload[PAYLOAD_W-1:0];
      end else if (is_tick && (phase_ff == PH_META) && item.link_ready) begin
         result.action = ACT_META;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_INIT;
         next_block_ff <= '0;
         retries_ff    <= '0;
         acked_ff      <= 1'b1;
      end else if (step) begin
         phase_ff      <= phase_in;
         next_block_ff <= next_block_in;
         retries_ff    <= retries_in;
         acked_ff      <= acked_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/block_transfer_sender_fsm.sv =====
// Top level of the stop-and-wait block transfer sender: input register,
// state machine, result register. Depends on bts_pkg, bts_cfg, bts_core.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  cmd, link_ready, ack_block, negative
//   rsp      out        rsp_valid/rsp_ready  action, block_number, byte_offset,
//                                            payload_bytes, block_total, phase_now
//   csr      in/out     psel/penable/pready  image_bytes @0x0, retry_limit @0x4
//
// One event per cycle sustained while rsp_ready stays high; an event passes the input register,
// then the result register, where its result waits until rsp_ready takes it.
// The state update and result logic are combinational between those registers.
// The block count is computed when image_bytes is written, so events may follow at once.
// Reset is synchronous; no clearing pass.
// A stalled rsp side holds the result register and then the input register.
`default_nettype none

module block_transfer_sender_fsm #(
   parameter int BlockBytes = bts_pkg::BLOCK_BYTES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_cmd,
   input  wire logic                          req_link_ready,
   input  wire logic [bts_pkg::BLOCK_W-1:0]   req_ack_block,
   input  wire logic                          req_negative,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [bts_pkg::CODE_W-1:0]    rsp_action,
   output logic      [bts_pkg::BLOCK_W-1:0]   rsp_block_number,
   output logic      [bts_pkg::IMAGE_W-1:0]   rsp_byte_offset,
   output logic      [bts_pkg::PAYLOAD_W-1:0] rsp_payload_bytes,
   output logic      [bts_pkg::BLOCK_W-1:0]   rsp_block_total,
   output logic      [bts_pkg::CODE_W-1:0]    rsp_phase_now,

   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [bts_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [bts_pkg::DATA_W-1:0]    pwdata,
   output logic      [bts_pkg::DATA_W-1:0]    prdata,
   output logic                               pready
);
   import bts_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       s1_go;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   bts_cfg #(
      .BlockBytes (BlockBytes)
   ) u_cfg (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bts_core #(
      .BlockBytes (BlockBytes)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (s1_go),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Advance the held event whenever the result register is free or draining
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) s1_valid_in = 1'b1;
      else if (s1_go)             s1_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (s1_go)          rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff.cmd        <= req_cmd;
         s1_item_ff.link_ready <= req_link_ready;
         s1_item_ff.ack_block  <= req_ack_block;
         s1_item_ff.negative   <= req_negative;
      end
      if (s1_go) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_ff.action;
   assign rsp_block_number  = rsp_ff.block_number;
   assign rsp_byte_offset   = rsp_ff.byte_offset;
   assign rsp_payload_bytes = rsp_ff.payload_bytes;
   assign rsp_block_total   = rsp_ff.block_total;
   assign rsp_phase_now     = rsp_ff.phase_now;

   a_data_in_data_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.action == ACT_DATA)) |-> (rsp_ff.phase_now == PH_DATA))
      else $error("data send reported outside the data phase");

   a_abort_to_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.action == ACT_ABORT)) |-> (rsp_ff.phase_now == PH_ERROR))
      else $error("abort without error phase");

   a_finish_to_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.action == ACT_FINISH)) |-> (rsp_ff.phase_now == PH_DONE))
      else $error("finish without done phase");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.action != ACT_DATA)) |->
         ((rsp_ff.byte_offset == '0) && (rsp_ff.payload_bytes == '0)))
      else $error("offset or payload set without a data send");

   a_transfer_reaches_result: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_valid_ff)
      else $error("event advanced but no result registered");

endmodule

`default_nettype wire

// ===== dv/block_transfer_sender_fsm_test.sv =====
// Self-checking test of block_transfer_sender_fsm: random-gap driver and monitor,
// a cycle-free model of the stop-and-wait sender, and APB register setup.
// Depends on hdl/bts_pkg.sv and hdl/block_transfer_sender_fsm.sv.
`timescale 1ns / 1ps

module block_transfer_sender_fsm_test;
   import bts_pkg::*;

   localparam int unsigned ROUND_ITEMS  = 1410;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned LONG_HOLD    = 120;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned REPORT_CAP   = 40;

   typedef enum int unsigned {
      END_EMPTY_IMAGE,
      END_EXACT_SIZE,
      END_ZERO_LIMIT,
      END_RETRY_OUT
   } ending_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic                 req_cmd        = CMD_TICK;
   logic                 req_link_ready = 1'b0;
   logic [BLOCK_W-1:0]   req_ack_block  = '0;
   logic                 req_negative   = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CODE_W-1:0]    rsp_action;
   logic [BLOCK_W-1:0]   rsp_block_number;
   logic [IMAGE_W-1:0]   rsp_byte_offset;
   logic [PAYLOAD_W-1:0] rsp_payload_bytes;
   logic [BLOCK_W-1:0]   rsp_block_total;
   logic [CODE_W-1:0]    rsp_phase_now;

   logic                 psel    = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite  = 1'b0;
   logic [ADDR_W-1:0]    paddr   = '0;
   logic [DATA_W-1:0]    pwdata  = '0;
   logic [DATA_W-1:0]    prdata;
   logic                 pready;

   // sender model state and its copy of the registers
   phase_type          arq_phase       = PH_INIT;
   logic [BLOCK_W-1:0] arq_next_block  = '0;
   logic [RETRY_W-1:0] arq_retries     = '0;
   logic               arq_acked       = 1'b1;
   logic [IMAGE_W-1:0] reg_image_bytes = '0;
   logic [RETRY_W-1:0] reg_retry_limit = RETRY_RESET;

   item_type    pending_events[$];
   result_type  due_responses[$];
   int unsigned events_queued   = 0;
   int unsigned events_taken    = 0;
   int unsigned round_items     = 0;
   int unsigned mismatches      = 0;
   int unsigned quiet_cycles    = 0;
   int unsigned hold_requests   = 0;
   int unsigned holds_done      = 0;
   int unsigned send_gap        = 0;
   int unsigned send_calm       = 0;
   int unsigned recv_gap        = 0;
   int unsigned recv_calm       = 0;

   block_transfer_sender_fsm i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_link_ready    (req_link_ready),
      .req_ack_block     (req_ack_block),
      .req_negative      (req_negative),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_block_number  (rsp_block_number),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_payload_bytes (rsp_payload_bytes),
      .rsp_block_total   (rsp_block_total),
      .rsp_phase_now     (rsp_phase_now),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [BLOCK_W-1:0] blocks_in_image(input logic [IMAGE_W-1:0] bytes);
      logic [31:0] count;
      count = (32'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
      return (count > 32'hFFFF) ? BLOCK_MAX : count[BLOCK_W-1:0];
   endfunction

   // Apply one event to the sender model and return the response it owes.
   function automatic result_type advance_sender(input item_type ev);
      result_type         res;
      logic [BLOCK_W-1:0] total;
      logic [31:0]        offset;
      logic [31:0]        remain;
      total             = blocks_in_image(reg_image_bytes);
      res.action        = ACT_NONE;
      res.block_number  = arq_next_block;
      res.byte_offset   = '0;
      res.payload_bytes = '0;
      res.block_total   = total;
      if (ev.cmd == CMD_TICK) begin
         case (arq_phase)
            PH_INIT: begin
               if (ev.link_ready) arq_phase = PH_META;
            end
            PH_META: begin
               if (ev.link_ready) res.action = ACT_META;
            end
            PH_DATA: begin
               if (arq_next_block >= total) begin
                  arq_phase  = PH_DONE;
                  res.action = ACT_FINISH;
               end else begin
                  if (!arq_acked) begin
                     arq_retries = arq_retries + 8'd1;
                     if (arq_retries >= reg_retry_limit) begin
                        arq_phase  = PH_ERROR;
                        res.action = ACT_ABORT;
                     end
                  end else begin
                     arq_retries = '0;
                     arq_acked   = 1'b0;
                  end
                  if (res.action != ACT_ABORT && ev.link_ready) begin
                     offset            = 32'(arq_next_block) * BLOCK_BYTES;
                     remain            = (offset < reg_image_bytes) ? reg_image_bytes - offset : 0;
                     res.action        = ACT_DATA;
                     res.byte_offset   = offset[IMAGE_W-1:0];
                     res.payload_bytes = (remain >= BLOCK_BYTES) ? PAYLOAD_W'(BLOCK_BYTES)
                                                                : remain[PAYLOAD_W-1:0];
                  end
               end
            end
            default: ;
         endcase
      end else if (ev.ack_block == META_ACK) begin
         if (arq_phase == PH_META) arq_phase = PH_DATA;
      end else if (arq_phase == PH_DATA && !ev.negative && ev.ack_block == arq_next_block) begin
         arq_acked      = 1'b1;
         arq_next_block = arq_next_block + 16'd1;
      end
      res.phase_now = arq_phase;
      return res;
   endfunction

   function automatic int unsigned draw_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 88) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   task automatic check_field(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $display("%0t rsp_%s: expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // driver: one transfer at a time from pending_events, random gaps between them
   always @(posedge clock) begin
      item_type head;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_events.size() != 0) begin
            head = pending_events.pop_front();
            req_valid      <= 1'b1;
            req_cmd        <= head.cmd;
            req_link_ready <= head.link_ready;
            req_ack_block  <= head.ack_block;
            req_negative   <= head.negative;
            if (send_calm != 0) begin
               send_gap  <= 0;
               send_calm <= send_calm - 1;
            end else begin
               send_gap <= draw_gap();
               if ($urandom_range(0, 31) == 0) send_calm <= $urandom_range(20, 60);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold whenever one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done <= holds_done + 1;
         recv_gap   <= LONG_HOLD;
         rsp_ready  <= 1'b0;
      end else if (recv_gap != 0) begin
         rsp_ready <= 1'b0;
         recv_gap  <= recv_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (recv_calm != 0) begin
            recv_calm <= recv_calm - 1;
         end else if (rsp_valid && rsp_ready) begin
            recv_gap <= draw_gap();
            if ($urandom_range(0, 31) == 0) recv_calm <= $urandom_range(20, 60);
         end
      end
   end

   // monitor: check responses in order, predict on every accepted event, watch for hangs
   always @(posedge clock) begin
      result_type want;
      item_type   taken;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_responses.size() == 0) begin
               mismatches++;
               $display("%0t unexpected response: expected none, actual action %0d",
                        $time, rsp_action);
            end else begin
               want = due_responses.pop_front();
               check_field("action", want.action, rsp_action);
               check_field("block_number", want.block_number, rsp_block_number);
               check_field("byte_offset", want.byte_offset, rsp_byte_offset);
               check_field("payload_bytes", want.payload_bytes, rsp_payload_bytes);
               check_field("block_total", want.block_total, rsp_block_total);
               check_field("phase_now", want.phase_now, rsp_phase_now);
            end
         end
         if (req_valid && req_ready) begin
            taken.cmd        = req_cmd;
            taken.link_ready = req_link_ready;
            taken.ack_block  = req_ack_block;
            taken.negative   = req_negative;
            due_responses.push_back(advance_sender(taken));
            events_taken++;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic queue_event(input logic cmd, input logic link, input logic [BLOCK_W-1:0] ack,
                              input logic negative);
      item_type ev;
      ev.cmd        = cmd;
      ev.link_ready = link;
      ev.ack_block  = ack;
      ev.negative   = negative;
      pending_events.push_back(ev);
      events_queued++;
   endtask

   // Ack that must leave the sender unchanged while block nb is in flight.
   task automatic queue_stray_ack(input logic [BLOCK_W-1:0] nb);
      logic [BLOCK_W-1:0] value;
      logic               negative;
      negative = $urandom_range(0, 1);
      case ($urandom_range(0, 3))
         0: begin
            value = BLOCK_W'($urandom);
            if (!negative && value == nb) value = value ^ 16'd1;
         end
         1: begin
            value    = nb;
            negative = 1'b1;
         end
         2: begin
            value    = $urandom_range(0, 1) ? nb - 16'd1 : nb + 16'd1;
            negative = 1'b0;
         end
         default: value = META_ACK;
      endcase
      queue_event(CMD_ACK, $urandom_range(0, 1), value, negative);
      round_items++;
   endtask

   task automatic write_register(input logic reg_index, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({reg_index, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_index == REG_IMAGE_BYTES) reg_image_bytes = value[IMAGE_W-1:0];
      else reg_retry_limit = value[RETRY_W-1:0];
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (events_taken != events_queued || due_responses.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Well-formed stop-and-wait rounds: some ticks (never enough to abort), stray
   // acks mixed in, then the matching ack. Stop once the image is fully acked.
   task automatic send_rounds(input int unsigned rounds);
      logic [BLOCK_W-1:0] nb;
      logic [BLOCK_W-1:0] total;
      int unsigned        ticks;
      int unsigned        cap;
      int unsigned        r;
      nb    = arq_next_block;
      total = blocks_in_image(reg_image_bytes);
      r     = 0;
      while (r < rounds && nb < total) begin
         cap   = (reg_retry_limit < 3) ? reg_retry_limit : 3;
         ticks = ($urandom_range(0, 31) == 0) ? reg_retry_limit : $urandom_range(0, cap);
         repeat (ticks) begin
            if ($urandom_range(0, 3) == 0) queue_stray_ack(nb);
            queue_event(CMD_TICK, $urandom_range(0, 4) != 0, BLOCK_W'($urandom),
                        $urandom_range(0, 1));
            round_items++;
         end
         if ($urandom_range(0, 3) == 0) queue_stray_ack(nb);
         queue_event(CMD_ACK, $urandom_range(0, 1), nb, 1'b0);
         round_items++;
         nb = nb + 16'd1;
         r++;
      end
   endtask

   task automatic reconfigure();
      logic [BLOCK_W-1:0] nb;
      int unsigned        roll;
      logic [31:0]        image;
      nb = arq_next_block;
      if ($urandom_range(0, 2) == 0) begin
         roll = $urandom_range(0, 9);
         write_register(REG_RETRY_LIMIT, (roll == 0) ? 1 : (roll == 1) ? 255 : $urandom_range(2, 8));
      end
      // extend the image whenever every block so far has been acked
      if (blocks_in_image(reg_image_bytes) <= nb || $urandom_range(0, 2) == 0) begin
         roll = $urandom_range(0, 15);
         if (roll == 0) image = 32'h3F_FFFF;
         else if (roll == 1) image = 32'd4194240;
         else image = (32'(nb) + $urandom_range(0, 11)) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES);
         write_register(REG_IMAGE_BYTES, image);
      end
   endtask

   initial begin
      ending_type  ending;
      int unsigned limit;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_register(REG_IMAGE_BYTES, 32'h3F_FFFF);
      write_register(REG_RETRY_LIMIT, 32'd5);

      // init and metadata phases, then the first data blocks
      queue_event(CMD_ACK,  1'b0, META_ACK, 1'b0);
      queue_event(CMD_ACK,  1'b1, 16'h0000, 1'b1);
      queue_event(CMD_TICK, 1'b0, 16'h0000, 1'b0);
      queue_event(CMD_TICK, 1'b1, 16'hFFFF, 1'b1);
      queue_event(CMD_TICK, 1'b0, 16'h0000, 1'b0);
      queue_event(CMD_TICK, 1'b1, 16'h0000, 1'b0);
      queue_event(CMD_ACK,  1'b1, 16'h0000, 1'b0);
      queue_event(CMD_ACK,  1'b0, 16'hFFFE, 1'b0);
      queue_event(CMD_TICK, 1'b1, 16'h5555, 1'b1);
      queue_event(CMD_ACK,  1'b1, META_ACK, 1'b1);
      // ack before the block was ever sent still counts
      queue_event(CMD_ACK,  1'b0, 16'h0000, 1'b0);
      queue_event(CMD_TICK, 1'b1, 16'hAAAA, 1'b0);
      queue_event(CMD_ACK,  1'b1, 16'h0001, 1'b1);
      queue_event(CMD_ACK,  1'b1, 16'h0002, 1'b0);
      queue_event(CMD_ACK,  1'b1, 16'h0000, 1'b0);
      queue_event(CMD_ACK,  1'b1, META_ACK, 1'b0);
      // link down: retry is counted, nothing goes out
      queue_event(CMD_TICK, 1'b0, 16'h0000, 1'b0);
      queue_event(CMD_TICK, 1'b1, 16'h0000, 1'b0);
      queue_event(CMD_ACK,  1'b1, 16'h0001, 1'b0);
      queue_event(CMD_TICK, 1'b0, 16'h0000, 1'b0);
      queue_event(CMD_ACK,  1'b0, 16'h0002, 1'b0);
      wait_drained();

      // hold off the receiver while a long run of rounds is offered
      hold_requests <= hold_requests + 1;
      send_rounds(10);
      wait_drained();

      while (round_items < ROUND_ITEMS) begin
         reconfigure();
         send_rounds($urandom_range(2, 8));
         wait_drained();
      end

      // one way out of the data phase; no reset follows, so only one is possible
      ending = ending_type'($urandom_range(0, 3));
      case (ending)
         END_EMPTY_IMAGE: begin
            write_register(REG_IMAGE_BYTES, 32'd0);
            queue_event(CMD_TICK, $urandom_range(0, 1), BLOCK_W'($urandom), 1'b0);
         end
         END_EXACT_SIZE: begin
            write_register(REG_IMAGE_BYTES, 32'(arq_next_block) * BLOCK_BYTES);
            queue_event(CMD_TICK, 1'b1, BLOCK_W'($urandom), 1'b0);
         end
         END_ZERO_LIMIT: begin
            write_register(REG_RETRY_LIMIT, 32'd0);
            queue_event(CMD_TICK, 1'b1, BLOCK_W'($urandom), 1'b0);
            queue_event(CMD_TICK, $urandom_range(0, 1), BLOCK_W'($urandom), 1'b1);
         end
         default: begin
            limit = reg_retry_limit;
            repeat (limit + 1)
               queue_event(CMD_TICK, $urandom_range(0, 1), BLOCK_W'($urandom), 1'b0);
         end
      endcase
      repeat (8) begin
         if ($urandom_range(0, 1)) queue_event(CMD_TICK, 1'b1, BLOCK_W'($urandom), 1'b0);
         else queue_stray_ack(arq_next_block);
      end
      wait_drained();

      if (mismatches == 0 && due_responses.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
